// File: hdl/ttnr_pkg.sv
// ----------------------------------------------------------------------------
// ttnr_pkg - shared types and constants of the truncation top-n ranker
// Field widths, the ranked record held in each cell, the cell command
// group, the row status, the result item and the controller state encoding.
// ----------------------------------------------------------------------------
package ttnr_pkg;

    localparam int SLOT_W    = 10;
    localparam int FIELD_W   = 32;
    localparam int POS_W     = 4;
    localparam int SUM_W     = 48;
    localparam int SLOTS_W   = 12;

    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [SLOTS_W-1:0] SLOTS_MAX = {SLOTS_W{1'b1}};

    // one ranked record as held in a cell of the row
    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic               arch;
        logic [FIELD_W-1:0] trace_cuts;
        logic [FIELD_W-1:0] cmp_trunc;
        logic [FIELD_W-1:0] trace_peak;
        logic [FIELD_W-1:0] calls;
        logic [FIELD_W-1:0] win_count;
    } rec_t;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic insert;
        logic pop;
    } cell_cmd_t;

    // status of the head of the row, seen by the controller
    typedef struct packed {
        logic head_valid;
        logic second_valid;
    } chain_stat_t;

    // one result transaction
    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic               entry_valid;
        rec_t               rec;
        logic [SUM_W-1:0]   overflow_sum;
        logic [SLOTS_W-1:0] overflow_slots;
        logic               last_result;
    } out_item_t;

    typedef enum logic {
        ST_COLLECT,
        ST_EMIT
    } state_t;

endpackage

// File: hdl/ttnr_in_if.sv
// ----------------------------------------------------------------------------
// ttnr_in_if - record channel of the truncation top-n ranker
// Valid/ready channel carrying one per-slot counter record.
// ----------------------------------------------------------------------------
interface ttnr_in_if;

    logic                           valid;
    logic                           ready;
    logic [ttnr_pkg::SLOT_W-1:0]    slot_number;
    logic                           is_32bit;
    logic [ttnr_pkg::FIELD_W-1:0]   trace_cuts;
    logic [ttnr_pkg::FIELD_W-1:0]   cmp_trunc;
    logic [ttnr_pkg::FIELD_W-1:0]   trace_peak;
    logic [ttnr_pkg::FIELD_W-1:0]   probe_overflow;
    logic [ttnr_pkg::FIELD_W-1:0]   call_count;
    logic [ttnr_pkg::FIELD_W-1:0]   win_count;
    logic                           last_item;

    modport source (
        output valid, slot_number, is_32bit, trace_cuts, cmp_trunc, trace_peak,
               probe_overflow, call_count, win_count, last_item,
        input  ready
    );

    modport sink (
        input  valid, slot_number, is_32bit, trace_cuts, cmp_trunc, trace_peak,
               probe_overflow, call_count, win_count, last_item,
        output ready
    );

endinterface

// File: hdl/ttnr_out_if.sv
// ----------------------------------------------------------------------------
// ttnr_out_if - result channel of the truncation top-n ranker
// Valid/ready channel carrying one ranked entry together with the totals.
// ----------------------------------------------------------------------------
interface ttnr_out_if;

    logic                           valid;
    logic                           ready;
    logic [ttnr_pkg::POS_W-1:0]     position;
    logic                           entry_valid;
    logic [ttnr_pkg::SLOT_W-1:0]    out_slot;
    logic                           out_is_32bit;
    logic [ttnr_pkg::FIELD_W-1:0]   out_trace_cuts;
    logic [ttnr_pkg::FIELD_W-1:0]   out_cmp_trunc;
    logic [ttnr_pkg::FIELD_W-1:0]   out_trace_peak;
    logic [ttnr_pkg::FIELD_W-1:0]   out_calls;
    logic [ttnr_pkg::FIELD_W-1:0]   out_win_count;
    logic [ttnr_pkg::SUM_W-1:0]     overflow_sum;
    logic [ttnr_pkg::SLOTS_W-1:0]   overflow_slots;
    logic                           last_result;

    modport source (
        output valid, position, entry_valid, out_slot, out_is_32bit,
               out_trace_cuts, out_cmp_trunc, out_trace_peak, out_calls,
               out_win_count, overflow_sum, overflow_slots, last_result,
        input  ready
    );

    modport sink (
        input  valid, position, entry_valid, out_slot, out_is_32bit,
               out_trace_cuts, out_cmp_trunc, out_trace_peak, out_calls,
               out_win_count, overflow_sum, overflow_slots, last_result,
        output ready
    );

endinterface

// File: hdl/truncation_top_n_ranker.sv
// ----------------------------------------------------------------------------
// truncation_top_n_ranker - streaming top-n list of truncation counters
// Ranks per-slot records and emits the best TOP_ENTRIES with overflow totals.
// ----------------------------------------------------------------------------
// Usage
//   records : one per-slot counter record per transaction. While a scan is
//             collected one record is taken every cycle; each is ranked and,
//             if nonzero, offered to the compare-and-shift cells in that cycle.
//   results : on the record marked last_item the list is emitted, best
//             entry first, one transaction per cycle while the receiver is
//             ready; every transaction carries the overflow totals and the
//             final one has last_result set. An empty list gives a single
//             transaction with entry_valid low.
//   Order   : taking the last record moves the controller to its emit
//             state; from there the head of the row is loaded into the
//             output register, which drives results.valid, once that
//             register is empty or being taken. records.ready is low
//             while the list is unloaded; it rises again once the final
//             result sits in the output register, so the next scan may
//             start while it waits.
//   Stall   : a stalled receiver holds the output register and pauses the
//             unload; nothing is lost.
//   Reset   : empties the row, clears the totals and the output valid flag.
// ----------------------------------------------------------------------------
module truncation_top_n_ranker #(
    parameter int TOP_ENTRIES   = 10,
    parameter int COUNTER_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    ttnr_in_if.sink     records,
    ttnr_out_if.source  results
);

    localparam int CNT_W = (COUNTER_WIDTH < ttnr_pkg::FIELD_W) ? COUNTER_WIDTH
                                                              : ttnr_pkg::FIELD_W;
    localparam logic [ttnr_pkg::FIELD_W-1:0] CNT_MASK =
        {ttnr_pkg::FIELD_W{1'b1}} >> (ttnr_pkg::FIELD_W - CNT_W);

    ttnr_pkg::state_t               state_reg;
    ttnr_pkg::state_t               state_next;
    logic [ttnr_pkg::POS_W-1:0]     pos_reg;
    logic [ttnr_pkg::POS_W-1:0]     pos_next;
    logic [ttnr_pkg::SUM_W-1:0]     total_reg;
    logic [ttnr_pkg::SUM_W-1:0]     total_next;
    logic [ttnr_pkg::SLOTS_W-1:0]   count_reg;
    logic [ttnr_pkg::SLOTS_W-1:0]   count_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    ttnr_pkg::out_item_t            out_reg;
    ttnr_pkg::out_item_t            out_next;

    logic                           in_acc;
    logic                           emit_load;
    logic                           emit_last;
    logic [ttnr_pkg::FIELD_W-1:0]   tt;
    logic [ttnr_pkg::FIELD_W-1:0]   ct;
    logic [ttnr_pkg::FIELD_W-1:0]   mt;
    logic [ttnr_pkg::FIELD_W-1:0]   po;
    logic [ttnr_pkg::FIELD_W-1:0]   trace_rank;
    logic [ttnr_pkg::FIELD_W-1:0]   new_rank;
    logic [ttnr_pkg::SUM_W:0]       sum_wide;
    ttnr_pkg::rec_t                 new_rec;
    ttnr_pkg::rec_t                 head_rec;
    ttnr_pkg::chain_stat_t          stat;
    ttnr_pkg::cell_cmd_t            cmd;

    // record masking and rank
    assign tt         = records.trace_cuts & CNT_MASK;
    assign ct         = records.cmp_trunc & CNT_MASK;
    assign mt         = records.trace_peak & CNT_MASK;
    assign po         = records.probe_overflow & CNT_MASK;
    assign trace_rank = (tt > mt) ? tt : mt;
    assign new_rank   = (trace_rank != '0) ? trace_rank : ct;

    assign new_rec.slot       = records.slot_number;
    assign new_rec.arch       = records.is_32bit;
    assign new_rec.trace_cuts = tt;
    assign new_rec.cmp_trunc  = ct;
    assign new_rec.trace_peak = mt;
    assign new_rec.calls      = records.call_count & CNT_MASK;
    assign new_rec.win_count  = records.win_count & CNT_MASK;

    // handshakes
    assign records.ready = (state_reg == ttnr_pkg::ST_COLLECT);
    assign in_acc        = records.valid && records.ready;
    assign emit_load     = (state_reg == ttnr_pkg::ST_EMIT)
                           && (!out_valid_reg || results.ready);
    assign emit_last     = !stat.head_valid || !stat.second_valid;

    assign cmd.insert = in_acc && (new_rank != '0);
    assign cmd.pop    = emit_load;

    ttnr_chain #(
        .TOP_ENTRIES (TOP_ENTRIES)
    ) u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .new_rec  (new_rec),
        .new_rank (new_rank),
        .head_rec (head_rec),
        .stat     (stat)
    );

    // saturating overflow sum
    assign sum_wide = {1'b0, total_reg}
                    + {{(ttnr_pkg::SUM_W + 1 - ttnr_pkg::FIELD_W){1'b0}}, po};

    // control, totals and output register
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        total_next     = total_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ttnr_pkg::ST_COLLECT:
            begin
                if (in_acc)
                begin
                    if (po != '0)
                    begin
                        total_next = sum_wide[ttnr_pkg::SUM_W]
                                   ? ttnr_pkg::SUM_MAX
                                   : sum_wide[ttnr_pkg::SUM_W-1:0];
                        if (count_reg != ttnr_pkg::SLOTS_MAX)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    if (records.last_item)
                    begin
                        state_next = ttnr_pkg::ST_EMIT;
                    end
                end
            end
            ttnr_pkg::ST_EMIT:
            begin
                if (emit_load)
                begin
                    out_valid_next          = 1'b1;
                    out_next.position       = pos_reg;
                    out_next.entry_valid    = stat.head_valid;
                    out_next.rec            = stat.head_valid ? head_rec : '0;
                    out_next.overflow_sum   = total_reg;
                    out_next.overflow_slots = count_reg;
                    out_next.last_result    = emit_last;
                    if (emit_last)
                    begin
                        pos_next   = '0;
                        total_next = '0;
                        count_next = '0;
                        state_next = ttnr_pkg::ST_COLLECT;
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ttnr_pkg::ST_COLLECT;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ttnr_pkg::ST_COLLECT;
            pos_reg       <= '0;
            total_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            total_reg     <= total_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign results.valid          = out_valid_reg;
    assign results.position       = out_reg.position;
    assign results.entry_valid    = out_reg.entry_valid;
    assign results.out_slot       = out_reg.rec.slot;
    assign results.out_is_32bit   = out_reg.rec.arch;
    assign results.out_trace_cuts = out_reg.rec.trace_cuts;
    assign results.out_cmp_trunc  = out_reg.rec.cmp_trunc;
    assign results.out_trace_peak = out_reg.rec.trace_peak;
    assign results.out_calls      = out_reg.rec.calls;
    assign results.out_win_count  = out_reg.rec.win_count;
    assign results.overflow_sum   = out_reg.overflow_sum;
    assign results.overflow_slots = out_reg.overflow_slots;
    assign results.last_result    = out_reg.last_result;

    // a last record always starts the unload
    a_last_starts_emit : assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && records.last_item) |=> (state_reg == ttnr_pkg::ST_EMIT))
        else $error("last record did not start the unload");

    // an empty head during unload only happens for an empty list
    a_empty_only_first : assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ttnr_pkg::ST_EMIT) && !stat.head_valid) |-> (pos_reg == '0))
        else $error("row ran empty in the middle of the unload");

    // final result clears the totals and reopens the input
    a_final_clears : assert property (@(posedge clk) disable iff (!rst_n)
        (emit_load && emit_last) |=> ((total_reg == '0) && (count_reg == '0)
                                      && !stat.head_valid && records.ready))
        else $error("totals or row not cleared after final result");

endmodule

// File: hdl/ttnr_cell.sv
// ----------------------------------------------------------------------------
// ttnr_cell - one compare-and-shift cell of the ranking row
// Holds one ranked record. On insert it keeps, takes the new record or
// takes its upper neighbour's record; on pop it takes its lower neighbour's.
// ----------------------------------------------------------------------------
module ttnr_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ttnr_pkg::cell_cmd_t             cmd,
    input  ttnr_pkg::rec_t                  new_rec,
    input  logic [ttnr_pkg::FIELD_W-1:0]    new_rank,
    input  logic                            prev_take,
    input  ttnr_pkg::rec_t                  prev_rec,
    input  logic [ttnr_pkg::FIELD_W-1:0]    prev_rank,
    input  logic                            prev_valid,
    input  ttnr_pkg::rec_t                  next_rec,
    input  logic [ttnr_pkg::FIELD_W-1:0]    next_rank,
    input  logic                            next_valid,
    output ttnr_pkg::rec_t                  rec,
    output logic [ttnr_pkg::FIELD_W-1:0]    rank,
    output logic                            valid,
    output logic                            take
);

    ttnr_pkg::rec_t                 rec_reg;
    ttnr_pkg::rec_t                 rec_next;
    logic [ttnr_pkg::FIELD_W-1:0]   rank_reg;
    logic [ttnr_pkg::FIELD_W-1:0]   rank_next;
    logic                           valid_reg;
    logic                           valid_next;

    // new record goes here or above when strictly larger, or the cell is free
    assign take = !valid_reg || (new_rank > rank_reg);

    // cell update
    always_comb
    begin
        rec_next   = rec_reg;
        rank_next  = rank_reg;
        valid_next = valid_reg;
        if (cmd.pop)
        begin
            rec_next   = next_rec;
            rank_next  = next_rank;
            valid_next = next_valid;
        end
        else if (cmd.insert && take)
        begin
            if (prev_take)
            begin
                rec_next   = prev_rec;
                rank_next  = prev_rank;
                valid_next = prev_valid;
            end
            else
            begin
                rec_next   = new_rec;
                rank_next  = new_rank;
                valid_next = 1'b1;
            end
        end
    end

    // occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // record payload
    always_ff @(posedge clk)
    begin
        rec_reg  <= rec_next;
        rank_reg <= rank_next;
    end

    assign rec   = rec_reg;
    assign rank  = rank_reg;
    assign valid = valid_reg;

endmodule

// File: hdl/ttnr_chain.sv
// ----------------------------------------------------------------------------
// ttnr_chain - row of ranking cells
// Links the cells to their neighbours, broadcasts the new record and the
// command, and reports the head of the row to the controller.
// ----------------------------------------------------------------------------
module ttnr_chain #(
    parameter int TOP_ENTRIES = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ttnr_pkg::cell_cmd_t             cmd,
    input  ttnr_pkg::rec_t                  new_rec,
    input  logic [ttnr_pkg::FIELD_W-1:0]    new_rank,
    output ttnr_pkg::rec_t                  head_rec,
    output ttnr_pkg::chain_stat_t           stat
);

    ttnr_pkg::rec_t                 rec_w     [TOP_ENTRIES];
    logic [ttnr_pkg::FIELD_W-1:0]   rank_w    [TOP_ENTRIES];
    logic                           valid_w   [TOP_ENTRIES];
    logic                           take_w    [TOP_ENTRIES];
    ttnr_pkg::rec_t                 p_rec_w   [TOP_ENTRIES];
    logic [ttnr_pkg::FIELD_W-1:0]   p_rank_w  [TOP_ENTRIES];
    logic                           p_valid_w [TOP_ENTRIES];
    logic                           p_take_w  [TOP_ENTRIES];
    ttnr_pkg::rec_t                 n_rec_w   [TOP_ENTRIES];
    logic [ttnr_pkg::FIELD_W-1:0]   n_rank_w  [TOP_ENTRIES];
    logic                           n_valid_w [TOP_ENTRIES];
    logic [TOP_ENTRIES-1:0]         valid_vec;

    genvar i;
    generate
        for (i = 0; i < TOP_ENTRIES; i++)
        begin : g_cell
            // upper neighbour, none above the head
            if (i == 0)
            begin : g_head
                assign p_take_w[i]  = 1'b0;
                assign p_rec_w[i]   = new_rec;
                assign p_rank_w[i]  = new_rank;
                assign p_valid_w[i] = 1'b0;
            end
            else
            begin : g_body
                assign p_take_w[i]  = take_w[i-1];
                assign p_rec_w[i]   = rec_w[i-1];
                assign p_rank_w[i]  = rank_w[i-1];
                assign p_valid_w[i] = valid_w[i-1];
            end

            // lower neighbour, the tail pulls in an empty cell
            if (i == TOP_ENTRIES - 1)
            begin : g_tail
                assign n_rec_w[i]   = '0;
                assign n_rank_w[i]  = '0;
                assign n_valid_w[i] = 1'b0;
            end
            else
            begin : g_inner
                assign n_rec_w[i]   = rec_w[i+1];
                assign n_rank_w[i]  = rank_w[i+1];
                assign n_valid_w[i] = valid_w[i+1];
            end

            ttnr_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .new_rec    (new_rec),
                .new_rank   (new_rank),
                .prev_take  (p_take_w[i]),
                .prev_rec   (p_rec_w[i]),
                .prev_rank  (p_rank_w[i]),
                .prev_valid (p_valid_w[i]),
                .next_rec   (n_rec_w[i]),
                .next_rank  (n_rank_w[i]),
                .next_valid (n_valid_w[i]),
                .rec        (rec_w[i]),
                .rank       (rank_w[i]),
                .valid      (valid_w[i]),
                .take       (take_w[i])
            );

            assign valid_vec[i] = valid_w[i];
        end

        // does an entry follow the head
        if (TOP_ENTRIES > 1)
        begin : g_second
            assign stat.second_valid = valid_w[1];
        end
        else
        begin : g_single
            assign stat.second_valid = 1'b0;
        end
    endgenerate

    assign head_rec        = rec_w[0];
    assign stat.head_valid = valid_w[0];

    // occupied cells always form an unbroken run from the head
    a_valid_prefix : assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec >> 1) & ~valid_vec) == '0)
        else $error("ranking row has a gap");

endmodule
